[hw/rtl/clipped_alpha_blit_engine_macros.svh]
// ----------------------------------------------------------------------------
// Clipped alpha blit engine assertion macros
// Concurrent checks sampled on the rising clock and muted during reset.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_BLIT_ENGINE_MACROS_SVH
`define CLIPPED_ALPHA_BLIT_ENGINE_MACROS_SVH

// Same-cycle implication.
`define CABE_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CABE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/cabe_pkg.sv]
// ----------------------------------------------------------------------------
// Clipped alpha blit engine package
// Payload types, register indexes, widths and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package cabe_pkg;

   localparam int DEFAULT_MAX_SOURCE_DIM = 1024;
   localparam int DEFAULT_MAX_WINDOW_DIM = 2048;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam int PLACE_W     = 12;
   localparam int SRC_DIM_W   = 11;
   localparam int WIN_DIM_W   = 12;
   // Effective dimensions and coordinates, wide enough for 4096.
   localparam int DIM_W       = 13;
   localparam int POS_W       = 14;
   localparam int COORD_W     = 12;
   localparam int INDEX_W     = 22;
   localparam int PIXEL_W     = 32;
   localparam int CHAN_W      = 8;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PLACE_X       = 3'd0,
      REG_PLACE_Y       = 3'd1,
      REG_SOURCE_WIDTH  = 3'd2,
      REG_SOURCE_HEIGHT = 3'd3,
      REG_WINDOW_WIDTH  = 3'd4,
      REG_WINDOW_HEIGHT = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] source_pixel;
      logic [PIXEL_W-1:0] framebuffer_pixel;
   } req_data_type;

   typedef struct packed {
      logic               write_enable;
      logic [INDEX_W-1:0] target_index;
      logic [PIXEL_W-1:0] blended_pixel;
      logic               frame_done;
   } rsp_data_type;

   // Exact floor(x / 255) for x below 65280.
   function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
      logic [15:0] t;
      t = x + {8'd0, x[15:8]} + 16'd1;
      return t[15:8];
   endfunction

endpackage

[hw/rtl/clipped_alpha_blit_engine.sv]
// ----------------------------------------------------------------------------
// Clipped alpha blit engine
// Places a raster-order ARGB source at a signed offset in a window, clips,
// and alpha-blends each pixel over the framebuffer word given with it.
// ----------------------------------------------------------------------------
// Usage: one request carries a source pixel and the framebuffer word at its
// landing spot; one response comes back for every request, in order, with a
// write enable, the linear target index, the word to write and a frame-done
// flag on the last source pixel. Throughput is one pixel per clock while the
// response side does not stall; each request passes through the input
// register, then the response register. The row and column counters
// advance at request accept and are the only state carried between pixels.
// Program the registers only while the engine is empty; a size change
// mid-frame ends the row or frame early once a counter reaches the new last
// position.
module clipped_alpha_blit_engine #(
   parameter int MAX_SOURCE_DIM = cabe_pkg::DEFAULT_MAX_SOURCE_DIM,
   parameter int MAX_WINDOW_DIM = cabe_pkg::DEFAULT_MAX_WINDOW_DIM
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  cabe_pkg::req_data_type             req_data,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output cabe_pkg::rsp_data_type             rsp_data,
   // Register write port
   input  logic                               csr_write_enable,
   input  logic [cabe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cabe_pkg::CSR_DATA_W-1:0]    csr_wdata
);

`include "clipped_alpha_blit_engine_macros.svh"

   localparam int CNT_W = (MAX_SOURCE_DIM > 1) ? $clog2(MAX_SOURCE_DIM) : 1;
   localparam logic [cabe_pkg::DIM_W-1:0] SRC_MAX = cabe_pkg::DIM_W'(MAX_SOURCE_DIM);
   localparam logic [cabe_pkg::DIM_W-1:0] WIN_MAX = cabe_pkg::DIM_W'(MAX_WINDOW_DIM);

   // --------------------------------------------------------------------
   // Configuration registers
   // --------------------------------------------------------------------
   logic [cabe_pkg::PLACE_W-1:0]   place_x_ff, place_y_ff;
   logic [cabe_pkg::SRC_DIM_W-1:0] source_width_ff, source_height_ff;
   logic [cabe_pkg::WIN_DIM_W-1:0] window_width_ff, window_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         place_x_ff       <= '0;
         place_y_ff       <= '0;
         source_width_ff  <= cabe_pkg::SRC_DIM_W'(1);
         source_height_ff <= cabe_pkg::SRC_DIM_W'(1);
         window_width_ff  <= cabe_pkg::WIN_DIM_W'(1);
         window_height_ff <= cabe_pkg::WIN_DIM_W'(1);
      end else if (csr_write_enable) begin
         case (cabe_pkg::csr_index_type'(csr_index))
            cabe_pkg::REG_PLACE_X:       place_x_ff       <= csr_wdata;
            cabe_pkg::REG_PLACE_Y:       place_y_ff       <= csr_wdata;
            cabe_pkg::REG_SOURCE_WIDTH:  source_width_ff  <= csr_wdata[cabe_pkg::SRC_DIM_W-1:0];
            cabe_pkg::REG_SOURCE_HEIGHT: source_height_ff <= csr_wdata[cabe_pkg::SRC_DIM_W-1:0];
            cabe_pkg::REG_WINDOW_WIDTH:  window_width_ff  <= csr_wdata;
            cabe_pkg::REG_WINDOW_HEIGHT: window_height_ff <= csr_wdata;
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   // Effective sizes: zero acts as one, oversize clamps to the maximum.
   function automatic logic [cabe_pkg::DIM_W-1:0] clamp_dim(
      input logic [cabe_pkg::DIM_W-1:0] value,
      input logic [cabe_pkg::DIM_W-1:0] limit
   );
      if (value == '0)   return cabe_pkg::DIM_W'(1);
      if (value > limit) return limit;
      return value;
   endfunction

   logic [cabe_pkg::DIM_W-1:0] src_w, src_h, win_w, win_h;

   assign src_w = clamp_dim(cabe_pkg::DIM_W'(source_width_ff),  SRC_MAX);
   assign src_h = clamp_dim(cabe_pkg::DIM_W'(source_height_ff), SRC_MAX);
   assign win_w = clamp_dim(cabe_pkg::DIM_W'(window_width_ff),  WIN_MAX);
   assign win_h = clamp_dim(cabe_pkg::DIM_W'(window_height_ff), WIN_MAX);

   // --------------------------------------------------------------------
   // Handshake: two register stages, each advances when the next frees up
   // --------------------------------------------------------------------
   logic s1_valid_ff, rsp_valid_ff;
   logic rsp_advance, req_accept;

   assign rsp_advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !rsp_advance;
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;

   // --------------------------------------------------------------------
   // Raster counters and landing position (computed at accept)
   // --------------------------------------------------------------------
   logic [CNT_W-1:0] col_ff, row_ff, col_in, row_in;
   logic             last_col, last_row, done_in;
   logic [cabe_pkg::POS_W-1:0] pos_x, pos_y;
   logic             inside_in;

   assign last_col = cabe_pkg::DIM_W'(col_ff) >= (src_w - cabe_pkg::DIM_W'(1));
   assign last_row = cabe_pkg::DIM_W'(row_ff) >= (src_h - cabe_pkg::DIM_W'(1));
   assign done_in  = last_col && last_row;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + CNT_W'(1);
      end else begin
         col_in = col_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Signed placement plus unsigned counter; the top bit is the sign.
   assign pos_x = {{(cabe_pkg::POS_W-cabe_pkg::PLACE_W){place_x_ff[cabe_pkg::PLACE_W-1]}},
                   place_x_ff} + cabe_pkg::POS_W'(col_ff);
   assign pos_y = {{(cabe_pkg::POS_W-cabe_pkg::PLACE_W){place_y_ff[cabe_pkg::PLACE_W-1]}},
                   place_y_ff} + cabe_pkg::POS_W'(row_ff);

   assign inside_in = !pos_x[cabe_pkg::POS_W-1] && !pos_y[cabe_pkg::POS_W-1] &&
                      (pos_x < cabe_pkg::POS_W'(win_w)) &&
                      (pos_y < cabe_pkg::POS_W'(win_h));

   // --------------------------------------------------------------------
   // Input register
   // --------------------------------------------------------------------
   cabe_pkg::req_data_type         s1_data_ff;
   logic [cabe_pkg::COORD_W-1:0]   s1_u_ff, s1_v_ff;
   logic                           s1_inside_ff, s1_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   // Payload: hold while stalled, load on accept.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff   <= req_data;
         s1_u_ff      <= pos_x[cabe_pkg::COORD_W-1:0];
         s1_v_ff      <= pos_y[cabe_pkg::COORD_W-1:0];
         s1_inside_ff <= inside_in;
         s1_done_ff   <= done_in;
      end
   end

   // --------------------------------------------------------------------
   // Index and blend (between input and response registers)
   // --------------------------------------------------------------------
   logic [cabe_pkg::CHAN_W-1:0]  alpha, alpha_inv;
   logic [cabe_pkg::CHAN_W-1:0]  blend_chan [3];
   logic [cabe_pkg::COORD_W+cabe_pkg::DIM_W-1:0] row_base;
   logic [cabe_pkg::INDEX_W-1:0] index_calc;
   cabe_pkg::rsp_data_type       rsp_data_in;

   assign alpha     = s1_data_ff.source_pixel[31:24];
   assign alpha_inv = cabe_pkg::ALPHA_OPAQUE - alpha;
   assign row_base  = s1_v_ff * win_w;
   assign index_calc = row_base[cabe_pkg::INDEX_W-1:0] +
                       cabe_pkg::INDEX_W'(s1_u_ff);

   always_comb begin
      logic [15:0] src_term, dst_term;
      for (int c = 0; c < 3; c++) begin
         src_term = s1_data_ff.source_pixel[c*8 +: 8] * alpha;
         dst_term = s1_data_ff.framebuffer_pixel[c*8 +: 8] * alpha_inv;
         blend_chan[c] = cabe_pkg::div255(src_term) + cabe_pkg::div255(dst_term);
      end
   end

   always_comb begin
      rsp_data_in.write_enable  = 1'b0;
      rsp_data_in.target_index  = '0;
      rsp_data_in.blended_pixel = '0;
      rsp_data_in.frame_done    = s1_done_ff;
      if (s1_inside_ff) begin
         rsp_data_in.target_index = index_calc;
         if (alpha == cabe_pkg::ALPHA_CLEAR) begin
            // Transparent: pass the framebuffer word, no write.
            rsp_data_in.blended_pixel = s1_data_ff.framebuffer_pixel;
         end else if (alpha == cabe_pkg::ALPHA_OPAQUE) begin
            rsp_data_in.write_enable  = 1'b1;
            rsp_data_in.blended_pixel = s1_data_ff.source_pixel;
         end else begin
            // Keep destination alpha, blend each color channel.
            rsp_data_in.write_enable  = 1'b1;
            rsp_data_in.blended_pixel = {s1_data_ff.framebuffer_pixel[31:24],
                                         blend_chan[2], blend_chan[1], blend_chan[0]};
         end
      end
   end

   // --------------------------------------------------------------------
   // Response register
   // --------------------------------------------------------------------
   cabe_pkg::rsp_data_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_advance && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_data = rsp_data_ff;

   // --------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------
   `CABE_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, req_stall, s1_valid_ff && rsp_valid_ff, "request stalled with a free stage")
   `CABE_ASSERT_NEXT(a_frame_end_clears, clock, reset, req_accept && done_in, col_ff == '0 && row_ff == '0, "counters not cleared at frame end")
   `CABE_ASSERT_NEXT(a_input_holds, clock, reset, s1_valid_ff && !rsp_advance, s1_valid_ff && $stable(s1_data_ff) && $stable(s1_done_ff), "input stage lost a held request")

endmodule

[verif/clipped_alpha_blit_checker.sv]
// ----------------------------------------------------------------------------
// Clipped alpha blit checker
// Tracks register writes and accepted requests, predicts the response of
// each request (placement, clipping, blend, raster counters) and compares
// every accepted response, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module clipped_alpha_blit_checker
   import cabe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_data_type           req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_data_type           rsp_data,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending_count,
   output int                     write_count,
   output int                     clip_count,
   output int                     frame_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FULL_SCALE = 255;

   logic [PLACE_W-1:0]   place_x;
   logic [PLACE_W-1:0]   place_y;
   logic [SRC_DIM_W-1:0] source_w;
   logic [SRC_DIM_W-1:0] source_h;
   logic [WIN_DIM_W-1:0] window_w;
   logic [WIN_DIM_W-1:0] window_h;
   int                   column_pos;
   int                   row_pos;
   int                   response_seen;
   rsp_data_type         predicted_blits[$];

   function automatic int effective_dim(input int raw, input int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic logic [CHAN_W-1:0] mix_channel(input int unsigned s, input int unsigned d,
                                                      input int unsigned a);
      return CHAN_W'((s * a) / FULL_SCALE + (d * (FULL_SCALE - a)) / FULL_SCALE);
   endfunction

   function automatic logic [PIXEL_W-1:0] blend_over(input logic [PIXEL_W-1:0] src,
                                                     input logic [PIXEL_W-1:0] dst);
      logic [CHAN_W-1:0] alpha;
      alpha = src[31:24];
      if (alpha == ALPHA_OPAQUE) return src;
      return {dst[31:24],
              mix_channel(32'(src[23:16]), 32'(dst[23:16]), 32'(alpha)),
              mix_channel(32'(src[15:8]),  32'(dst[15:8]),  32'(alpha)),
              mix_channel(32'(src[7:0]),   32'(dst[7:0]),   32'(alpha))};
   endfunction

   task automatic predict_blit(input req_data_type req);
      int           sw;
      int           sh;
      int           ww;
      int           wh;
      int           u;
      int           v;
      rsp_data_type outcome;
      sw = effective_dim(int'(source_w), DEFAULT_MAX_SOURCE_DIM);
      sh = effective_dim(int'(source_h), DEFAULT_MAX_SOURCE_DIM);
      ww = effective_dim(int'(window_w), DEFAULT_MAX_WINDOW_DIM);
      wh = effective_dim(int'(window_h), DEFAULT_MAX_WINDOW_DIM);
      u  = int'($signed(place_x)) + column_pos;
      v  = int'($signed(place_y)) + row_pos;
      outcome = '0;
      if (u >= 0 && v >= 0 && u < ww && v < wh) begin
         outcome.target_index = INDEX_W'(u + v * ww);
         if (req.source_pixel[31:24] == ALPHA_CLEAR) begin
            outcome.blended_pixel = req.framebuffer_pixel;
         end else begin
            outcome.write_enable  = 1'b1;
            outcome.blended_pixel = blend_over(req.source_pixel, req.framebuffer_pixel);
            write_count++;
         end
      end else begin
         clip_count++;
      end
      // Counters past a shrunken size end the row or frame right away.
      if (column_pos >= sw - 1) begin
         column_pos = 0;
         if (row_pos >= sh - 1) begin
            row_pos = 0;
            outcome.frame_done = 1'b1;
            frame_count++;
         end else begin
            row_pos++;
         end
      end else begin
         column_pos++;
      end
      predicted_blits.push_back(outcome);
   endtask

   function automatic void compare_field(input string field, input logic [PIXEL_W-1:0] want,
                                         input logic [PIXEL_W-1:0] got);
      if (want !== got) begin
         $error("response %0d: %s expected 0x%0h, actual 0x%0h",
                response_seen, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         place_x    = '0;
         place_y    = '0;
         source_w   = SRC_DIM_W'(1);
         source_h   = SRC_DIM_W'(1);
         window_w   = WIN_DIM_W'(1);
         window_h   = WIN_DIM_W'(1);
         column_pos = 0;
         row_pos    = 0;
         predicted_blits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_blits.size() == 0) begin
               $error("response %0d arrived with no request outstanding", response_seen);
               fail_count++;
            end else begin
               rsp_data_type want;
               want = predicted_blits.pop_front();
               compare_field("write_enable",  PIXEL_W'(want.write_enable),
                             PIXEL_W'(rsp_data.write_enable));
               compare_field("target_index",  PIXEL_W'(want.target_index),
                             PIXEL_W'(rsp_data.target_index));
               compare_field("blended_pixel", want.blended_pixel, rsp_data.blended_pixel);
               compare_field("frame_done",    PIXEL_W'(want.frame_done),
                             PIXEL_W'(rsp_data.frame_done));
            end
            response_seen++;
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_PLACE_X:       place_x  = csr_wdata;
               REG_PLACE_Y:       place_y  = csr_wdata;
               REG_SOURCE_WIDTH:  source_w = csr_wdata[SRC_DIM_W-1:0];
               REG_SOURCE_HEIGHT: source_h = csr_wdata[SRC_DIM_W-1:0];
               REG_WINDOW_WIDTH:  window_w = csr_wdata;
               REG_WINDOW_HEIGHT: window_h = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_blit(req_data);
      end
      pending_count = predicted_blits.size();
   end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Clipped alpha blit engine testbench
// Drives blend requests through a series of placement, source and window
// settings with random request gaps and response stalls; a checker beside
// the engine predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import cabe_pkg::*;

   // Register indexes the engine does not decode; writes to them must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   localparam int RANDOM_PIXELS = 1030;
   // Final stretch of the random part runs with no gaps and no stalls.
   localparam int CALM_PIXELS   = 120;
   // Pipeline is two deep; leave a little margin after the last response.
   localparam int SETTLE_CYCLES = 6;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_data_type           req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int fail_count;
   int pending_count;
   int write_count;
   int clip_count;
   int frame_count;

   // Percent chance per request / per cycle of starting an idle burst.
   int unsigned gap_odds   = 0;
   int unsigned stall_odds = 0;
   int          sent_count = 0;
   int          setting_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   clipped_alpha_blit_engine DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   clipped_alpha_blit_checker blit_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .write_count      (write_count),
      .clip_count       (clip_count),
      .frame_count      (frame_count)
   );

   // Offer one request, after an optional idle burst, and hold it until taken.
   // Valid is left high on return so back-to-back requests see no bubble.
   task automatic send_pixel(input req_data_type pix);
      int unsigned burst;
      @(negedge clock);
      if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
         burst = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (burst) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Drop valid, then wait until every predicted response has come back and
   // the pipeline has had time to settle, so the registers can be changed.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_blit(input logic [CSR_DATA_W-1:0] px, input logic [CSR_DATA_W-1:0] py,
                               input logic [CSR_DATA_W-1:0] sw, input logic [CSR_DATA_W-1:0] sh,
                               input logic [CSR_DATA_W-1:0] ww, input logic [CSR_DATA_W-1:0] wh);
      write_reg(REG_PLACE_X, px);
      write_reg(REG_PLACE_Y, py);
      write_reg(REG_SOURCE_WIDTH, sw);
      write_reg(REG_SOURCE_HEIGHT, sh);
      write_reg(REG_WINDOW_WIDTH, ww);
      write_reg(REG_WINDOW_HEIGHT, wh);
      setting_count++;
   endtask

   // Random content with plenty of fully clear and fully opaque sources.
   function automatic req_data_type random_pixel();
      req_data_type pix;
      pix.source_pixel      = $urandom;
      pix.framebuffer_pixel = $urandom;
      case ($urandom_range(0, 4))
         0: pix.source_pixel[31:24] = ALPHA_CLEAR;
         1: pix.source_pixel[31:24] = ALPHA_OPAQUE;
         default: ;
      endcase
      return pix;
   endfunction

   // Mostly small sources so frames complete often; now and then zero,
   // oversize or full-size values.
   function automatic logic [CSR_DATA_W-1:0] random_source_dim();
      case ($urandom_range(0, 19))
         0:          return '0;
         1:          return CSR_DATA_W'($urandom_range(1025, 4095));
         2:          return CSR_DATA_W'(DEFAULT_MAX_SOURCE_DIM);
         3, 4, 5:    return CSR_DATA_W'($urandom_range(9, 40));
         default:    return CSR_DATA_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_window_dim();
      case ($urandom_range(0, 19))
         0:             return '0;
         1:             return CSR_DATA_W'($urandom_range(2049, 4095));
         2:             return CSR_DATA_W'(DEFAULT_MAX_WINDOW_DIM);
         3, 4, 5, 6:    return CSR_DATA_W'($urandom_range(17, 300));
         default:       return CSR_DATA_W'($urandom_range(1, 16));
      endcase
   endfunction

   // Placement near the window origin so pixels straddle the clip edges,
   // with an occasional placement anywhere in the signed range.
   function automatic logic [CSR_DATA_W-1:0] random_place();
      if ($urandom_range(0, 7) == 0) return CSR_DATA_W'($urandom_range(0, 4095));
      return CSR_DATA_W'(int'($urandom_range(0, 40)) - 12);
   endfunction

   function automatic int unsigned random_odds();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 45;
      endcase
   endfunction

   // Rewrite a random subset of registers; untouched ones keep their value,
   // and the raster counters carry over, so a shrink lands mid-frame.
   task automatic pick_setting();
      if ($urandom_range(0, 4) != 0) write_reg(REG_PLACE_X, random_place());
      if ($urandom_range(0, 4) != 0) write_reg(REG_PLACE_Y, random_place());
      if ($urandom_range(0, 4) != 0) write_reg(REG_SOURCE_WIDTH, random_source_dim());
      if ($urandom_range(0, 4) != 0) write_reg(REG_SOURCE_HEIGHT, random_source_dim());
      if ($urandom_range(0, 4) != 0) write_reg(REG_WINDOW_WIDTH, random_window_dim());
      if ($urandom_range(0, 4) != 0) write_reg(REG_WINDOW_HEIGHT, random_window_dim());
      if ($urandom_range(0, 9) == 0) write_reg(CSR_SPARE_LOW, CSR_DATA_W'($urandom));
      setting_count++;
   endtask

   // Response-side stall bursts, re-rolled at each falling edge outside a burst.
   initial begin
      int unsigned hold;
      forever begin
         @(negedge clock);
         if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
            hold = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int random_sent;
      int burst;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: 1x1 source in a 1x1 window at the origin. Every request
      // lands on index 0 and ends a frame. Cover clear, opaque and the alpha
      // extremes with saturated channels on both sides.
      send_pixel({32'h00123456, 32'h89ABCDEF});
      send_pixel({32'hFFFFFFFF, 32'h00000000});
      send_pixel({32'h01FFFFFF, 32'h00000000});
      send_pixel({32'hFE00FF00, 32'hFFFFFFFF});
      send_pixel({32'h80FF00FF, 32'h7F00FF00});

      // One column left of the origin in a 3x1 window: the first column and
      // the whole second row clip.
      drain_pipeline();
      program_blit(12'hFFF, 12'h000, 12'd4, 12'd2, 12'd3, 12'd1);
      repeat (8) send_pixel(random_pixel());

      // Far corner of the largest window, with zero source size acting as one:
      // the landing index is the top of the index range.
      drain_pipeline();
      program_blit(12'h7FF, 12'h7FF, 12'h000, 12'h000, 12'h800, 12'h800);
      send_pixel({32'hFF0F1E2D, 32'h12345678});
      send_pixel({32'h40C0C0C0, 32'hA0303030});

      // Oversize everything and push the source to the most negative spot:
      // all of it clips, and the column counter is left part way along a row.
      drain_pipeline();
      program_blit(12'h800, 12'h800, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      repeat (3) send_pixel(random_pixel());

      // Writes to undecoded indexes must not disturb anything; then shrink the
      // source to 1x1 mid-row so the stale column ends the frame at once.
      drain_pipeline();
      write_reg(CSR_SPARE_LOW, 12'hFFF);
      write_reg(CSR_SPARE_HIGH, 12'h000);
      write_reg(CSR_SPARE_HIGH, 12'hFFF);
      program_blit(12'h000, 12'h000, 12'd1, 12'd1, 12'h800, 12'h800);
      send_pixel({32'hFFAABBCC, 32'h00000000});
      send_pixel(random_pixel());

      // Random settings, each followed by a burst of random requests.
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         drain_pipeline();
         pick_setting();
         if (random_sent >= RANDOM_PIXELS - CALM_PIXELS) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = random_odds();
            stall_odds = random_odds();
         end
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            send_pixel(random_pixel());
            random_sent++;
         end
      end

      drain_pipeline();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Blit run: %0d requests over %0d register settings with random gaps and stalls",
               sent_count, setting_count);
      $display("  %0d pixels written, %0d clipped, %0d frames completed",
               write_count, clip_count, frame_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
